// ===== rtl/ppm_frame_generator_macros.svh =====
// Assertion macros used by the PPM frame generator top level.
`ifndef PPM_FRAME_GENERATOR_MACROS_SVH
`define PPM_FRAME_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PPMFG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PPMFG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ppmfg_pkg.sv =====
// Shared constants, codes and types of the PPM frame generator.
package ppmfg_pkg;

   // Table and timer sizing.
   localparam int MAX_CHANNELS   = 16;
   localparam int TIME_BITS      = 32;
   localparam int TBL_ADDR_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   // Field widths fixed by the interface.
   localparam int SLOT_BITS      = 5;
   localparam int WIDTH_BITS     = 16;
   localparam int INDEX_BITS     = 4;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Reset values.
   localparam logic [WIDTH_BITS-1:0] DEFAULT_WIDTH        = 16'd1500;
   localparam logic [SLOT_BITS-1:0]  RESET_NUM_CHANNELS   = 5'd8;
   localparam logic [15:0]           RESET_GAP_LENGTH     = 16'd300;
   localparam logic [15:0]           RESET_FRAME_LENGTH   = 16'd22500;

   // Input commands.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_HALT    = 2'd3
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NUM_CHANNELS  = 3'd0,
      CSR_INVERT_OUTPUT = 3'd1,
      CSR_GAP_LENGTH    = 3'd2,
      CSR_FRAME_LENGTH  = 3'd3
   } csr_index_type;

   // Configuration as seen by the sequencer.
   typedef struct packed {
      logic [SLOT_BITS-1:0] num_channels;
      logic                 invert_output;
      logic [15:0]          gap_length;
      logic [15:0]          frame_length;
   } cfg_type;

   // One result transaction.
   typedef struct packed {
      logic                 line_level;
      logic [SLOT_BITS-1:0] slot;
      logic                 frame_begun;
      logic                 running;
   } rsp_type;

   // Write port of the width table.
   typedef struct packed {
      logic                     en;
      logic [TBL_ADDR_BITS-1:0] addr;
      logic [WIDTH_BITS-1:0]    data;
   } wr_type;

endpackage

// ===== rtl/ppmfg_width_mem.sv =====
// Channel width table: synchronous memory with reset valid bits and write forwarding.
module ppmfg_width_mem (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ppmfg_pkg::wr_type                    wr,
   input  logic [ppmfg_pkg::TBL_ADDR_BITS-1:0]  rd_addr,
   output logic [ppmfg_pkg::WIDTH_BITS-1:0]     rd_width
);

   logic [ppmfg_pkg::WIDTH_BITS-1:0] mem [ppmfg_pkg::MAX_CHANNELS];
   logic [ppmfg_pkg::MAX_CHANNELS-1:0] valid_ff;
   logic [ppmfg_pkg::MAX_CHANNELS-1:0] valid_in;
   logic [ppmfg_pkg::WIDTH_BITS-1:0] rd_data_ff;
   logic [ppmfg_pkg::WIDTH_BITS-1:0] fwd_data_ff;
   logic                             fwd_hit_ff;
   logic                             fwd_hit_in;
   logic                             rd_valid_ff;
   logic                             rd_valid_in;

   // A write to the entry being read this cycle is forwarded around the array.
   assign fwd_hit_in  = wr.en && (wr.addr == rd_addr);
   assign rd_valid_in = valid_ff[rd_addr];

   // Valid bits: set by the first write of an entry.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   // Array write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff  <= mem[rd_addr];
      fwd_data_ff <= wr.data;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         fwd_hit_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         fwd_hit_ff  <= fwd_hit_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // Entries never written read as the default width.
   assign rd_width = fwd_hit_ff  ? fwd_data_ff :
                     rd_valid_ff ? rd_data_ff  : ppmfg_pkg::DEFAULT_WIDTH;

endmodule

// ===== rtl/ppmfg_core.sv =====
// Frame sequencer: timer, deadline compare, phase and slot state, width prefetch address.
module ppmfg_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  ppmfg_pkg::cmd_type                   cmd,
   input  ppmfg_pkg::cfg_type                   cfg,
   input  logic [ppmfg_pkg::WIDTH_BITS-1:0]     width,
   output logic [ppmfg_pkg::TBL_ADDR_BITS-1:0]  rd_addr,
   output ppmfg_pkg::rsp_type                   result
);

   localparam int TB = ppmfg_pkg::TIME_BITS;
   localparam int SB = ppmfg_pkg::SLOT_BITS;

   logic [TB-1:0] tick_ff,  tick_in;
   logic [TB-1:0] deadline_ff, deadline_in;
   logic [TB-1:0] frame_start_ff, frame_start_in;
   logic          in_gap_ff, in_gap_in;
   logic [SB-1:0] next_slot_ff, next_slot_in;
   logic          running_ff, running_in;
   logic          active_ff, active_in;

   logic [TB-1:0] tick_inc;
   logic [TB-1:0] diff;
   logic          ahead;
   logic [SB-1:0] eff_channels;
   logic          begun;

   // Timer compare against the deadline, modulo the counter range.
   assign tick_inc = tick_ff + TB'(1);
   assign diff     = deadline_ff - tick_inc;
   assign ahead    = (|diff) && !diff[TB-1];

   // Channel counts above the table size act as the table size.
   assign eff_channels = (32'(cfg.num_channels) > ppmfg_pkg::MAX_CHANNELS) ?
                         SB'(ppmfg_pkg::MAX_CHANNELS) : cfg.num_channels;

   // Next state for the accepted transaction.
   always_comb begin
      tick_in        = tick_ff;
      deadline_in    = deadline_ff;
      frame_start_in = frame_start_ff;
      in_gap_in      = in_gap_ff;
      next_slot_in   = next_slot_ff;
      running_in     = running_ff;
      active_in      = active_ff;
      begun          = 1'b0;
      if (step_en) begin
         case (cmd)
            ppmfg_pkg::CMD_TICK: begin
               tick_in = tick_inc;
               if (running_ff && !ahead) begin
                  if (in_gap_ff) begin
                     active_in   = 1'b0;
                     deadline_in = tick_inc + TB'(cfg.gap_length);
                  end else begin
                     if (next_slot_ff == '0) begin
                        frame_start_in = tick_inc;
                        begun          = 1'b1;
                     end
                     active_in = 1'b1;
                     if (next_slot_ff < eff_channels) begin
                        deadline_in  = tick_inc + TB'(width);
                        next_slot_in = next_slot_ff + SB'(1);
                     end else begin
                        deadline_in  = frame_start_in + TB'(cfg.frame_length)
                                       - TB'(cfg.gap_length);
                        next_slot_in = '0;
                     end
                  end
                  in_gap_in = !in_gap_ff;
               end
            end
            ppmfg_pkg::CMD_WRITE: begin
               // The table write goes straight to the memory.
            end
            ppmfg_pkg::CMD_RESTART: begin
               running_in     = 1'b1;
               in_gap_in      = 1'b0;
               tick_in        = '0;
               frame_start_in = '0;
               deadline_in    = '0;
               next_slot_in   = '0;
               active_in      = 1'b0;
            end
            ppmfg_pkg::CMD_HALT: begin
               running_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         deadline_ff    <= '0;
         frame_start_ff <= '0;
         in_gap_ff      <= 1'b0;
         next_slot_ff   <= '0;
         running_ff     <= 1'b0;
         active_ff      <= 1'b0;
      end else begin
         tick_ff        <= tick_in;
         deadline_ff    <= deadline_in;
         frame_start_ff <= frame_start_in;
         in_gap_ff      <= in_gap_in;
         next_slot_ff   <= next_slot_in;
         running_ff     <= running_in;
         active_ff      <= active_in;
      end
   end

   // Prefetch the width of the slot that the next transaction may start.
   assign rd_addr = ppmfg_pkg::TBL_ADDR_BITS'(next_slot_in);

   // Result of the accepted transaction.
   assign result.line_level  = active_in ^ cfg.invert_output;
   assign result.slot        = next_slot_in;
   assign result.frame_begun = begun;
   assign result.running     = running_in;

endmodule

// ===== rtl/ppm_frame_generator.sv =====
// Top level of the PPM frame generator: handshakes, configuration and output skid.
//
// Usage: each request transaction carries a command. A tick advances the frame
// timer by one and may start the next active phase or idle gap; a write stores
// one channel width; restart clears time, slot and phase and enables output
// with the line idle; halt stops phase changes while time keeps running.
// Every request yields exactly one response with the line level, the next
// slot, a frame-start flag and the running flag after that command.
// Each response is registered in the output entry, or in the skid entry if
// the output is stalled. Throughput is one request per cycle with req_stall
// low, set by the sequencer update and the width memory, whose read of the
// next slot is issued in the same cycle that the slot changes. A two-entry
// output stage (register plus skid) lets the block take a request while the
// previous response is stalled; req_stall rises only when both are full.
// Configuration goes through the csr channel, which is always ready; write it
// only while no response is pending. Reset is synchronous: it clears the
// timer state, loads the default registers, and marks every channel width as
// the default of 1500 ticks without a clearing pass.
module ppm_frame_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ppmfg_pkg::CMD_BITS-1:0]         req_command,
   input  logic [ppmfg_pkg::INDEX_BITS-1:0]       req_channel_index,
   input  logic [ppmfg_pkg::WIDTH_BITS-1:0]       req_channel_width,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_line_level,
   output logic [ppmfg_pkg::SLOT_BITS-1:0]        rsp_slot,
   output logic                                   rsp_frame_begun,
   output logic                                   rsp_running,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ppmfg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ppmfg_pkg::CSR_DATA_BITS-1:0]    csr_data
);

`include "ppm_frame_generator_macros.svh"

   ppmfg_pkg::cfg_type cfg_ff, cfg_in;
   ppmfg_pkg::wr_type  wr;
   ppmfg_pkg::rsp_type result;
   ppmfg_pkg::rsp_type out_ff, out_in;
   ppmfg_pkg::rsp_type skid_ff, skid_in;
   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic               req_accept;
   logic               rsp_pop;
   ppmfg_pkg::cmd_type cmd;
   logic [ppmfg_pkg::TBL_ADDR_BITS-1:0] rd_addr;
   logic [ppmfg_pkg::WIDTH_BITS-1:0]    rd_width;

   // Handshakes.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_pop    = out_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;
   assign cmd        = ppmfg_pkg::cmd_type'(req_command);

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ppmfg_pkg::CSR_NUM_CHANNELS:  cfg_in.num_channels  = csr_data[4:0];
            ppmfg_pkg::CSR_INVERT_OUTPUT: cfg_in.invert_output = csr_data[0];
            ppmfg_pkg::CSR_GAP_LENGTH:    cfg_in.gap_length    = csr_data;
            ppmfg_pkg::CSR_FRAME_LENGTH:  cfg_in.frame_length  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels  <= ppmfg_pkg::RESET_NUM_CHANNELS;
         cfg_ff.invert_output <= 1'b0;
         cfg_ff.gap_length    <= ppmfg_pkg::RESET_GAP_LENGTH;
         cfg_ff.frame_length  <= ppmfg_pkg::RESET_FRAME_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Width writes; indexes beyond the table are dropped.
   assign wr.en   = req_accept && (cmd == ppmfg_pkg::CMD_WRITE) &&
                    (32'(req_channel_index) < ppmfg_pkg::MAX_CHANNELS);
   assign wr.addr = ppmfg_pkg::TBL_ADDR_BITS'(req_channel_index);
   assign wr.data = req_channel_width;

   ppmfg_width_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_width (rd_width)
   );

   ppmfg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_accept),
      .cmd     (cmd),
      .cfg     (cfg_ff),
      .width   (rd_width),
      .rd_addr (rd_addr),
      .result  (result)
   );

   // Output register with skid entry.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || rsp_pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_level  = out_ff.line_level;
   assign rsp_slot        = out_ff.slot;
   assign rsp_frame_begun = out_ff.frame_begun;
   assign rsp_running     = out_ff.running;

   // Checks on the output stage and the result contents.
   `PPMFG_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid entry without output entry")
   `PPMFG_ASSERT_NEXT(a_skid_fill, clock, reset, req_accept && out_valid_ff && rsp_stall, skid_valid_ff, "stalled response not kept in skid")
   `PPMFG_ASSERT_NOW(a_begun_running, clock, reset, rsp_valid && rsp_frame_begun, rsp_running && rsp_line_level != cfg_ff.invert_output, "frame start while not active")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the PPM frame generator: directed table, random phases, predictor.
`timescale 1ns / 100ps

module tb_top;
   import ppmfg_pkg::*;

   // Give up long after the slowest legal run would have finished.
   localparam int unsigned CYCLE_LIMIT = 100000;
   // Length of the receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES = 300;

   // One row of the directed table: a register write or a request transaction.
   typedef struct packed {
      bit                    to_csr;
      csr_index_type         reg_sel;
      logic [CSR_DATA_BITS-1:0] reg_value;
      cmd_type               cmd;
      logic [INDEX_BITS-1:0] index;
      logic [WIDTH_BITS-1:0] width;
      bit                    typed;
      rsp_type               want;
   } plan_row_type;

   // Directed part. Widths 1 and 0 go to slots 0 and 1, then short frames run
   // with zero gap and zero frame length, an inverted line, a halt, a channel
   // count above the table size, and a channel count dropped below the slot.
   localparam plan_row_type DIR_PLAN [31] = '{
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_HALT, 4'd0, 16'd0, 1'b1, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_WRITE, 4'd0, 16'd1, 1'b1, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_WRITE, 4'd1, 16'd0, 1'b1, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_WRITE, 4'd15, 16'hFFFF, 1'b1, '0},
      '{1'b1, CSR_NUM_CHANNELS, 16'd2, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b1, CSR_GAP_LENGTH, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b1, CSR_FRAME_LENGTH, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_RESTART, 4'd0, 16'd0, 1'b1,
        '{1'b0, 5'd0, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd1, 1'b1, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b0, 5'd1, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd2, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b0, 5'd2, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd0, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b0, 5'd0, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd1, 1'b1, 1'b1}},
      '{1'b1, CSR_INVERT_OUTPUT, 16'd1, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd1, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_HALT, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd1, 1'b0, 1'b0}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd1, 1'b0, 1'b0}},
      '{1'b1, CSR_NUM_CHANNELS, 16'd31, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b1, CSR_INVERT_OUTPUT, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_RESTART, 4'd0, 16'd0, 1'b1,
        '{1'b0, 5'd0, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b1, 5'd1, 1'b1, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b1,
        '{1'b0, 5'd1, 1'b0, 1'b1}},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b1, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0},
      '{1'b0, CSR_NUM_CHANNELS, 16'd0, CMD_TICK, 4'd0, 16'd0, 1'b0, '0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   cmd_type                   req_command;
   logic [INDEX_BITS-1:0]     req_channel_index;
   logic [WIDTH_BITS-1:0]     req_channel_width;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_line_level;
   logic [SLOT_BITS-1:0]      rsp_slot;
   logic                      rsp_frame_begun;
   logic                      rsp_running;
   logic                      csr_valid;
   logic                      csr_ready;
   csr_index_type             csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   // Predicted generator state and its copy of the configuration.
   cfg_type                   ppm_cfg;
   logic [TIME_BITS-1:0]      ppm_time;
   logic [TIME_BITS-1:0]      ppm_deadline;
   logic [TIME_BITS-1:0]      ppm_frame_start;
   logic                      ppm_in_gap;
   logic [SLOT_BITS-1:0]      ppm_slot;
   logic                      ppm_running;
   logic                      ppm_pulse;
   logic [WIDTH_BITS-1:0]     ppm_widths [MAX_CHANNELS];

   // Expected line states, oldest first.
   rsp_type                   expected_line_states [$];
   int                        mismatch_count;
   int unsigned               cycle_count;
   int                        burst_left;
   bit                        stall_hold_request;

   ppm_frame_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_channel_index (req_channel_index),
      .req_channel_width (req_channel_width),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_line_level    (rsp_line_level),
      .rsp_slot          (rsp_slot),
      .rsp_frame_begun   (rsp_frame_begun),
      .rsp_running       (rsp_running),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Advance the predicted generator by one request transaction.
   function automatic rsp_type ppm_advance(cmd_type cmd, logic [INDEX_BITS-1:0] index,
                                           logic [WIDTH_BITS-1:0] width);
      rsp_type              line_state;
      logic [TIME_BITS-1:0] lead;
      logic [SLOT_BITS-1:0] slots_used;
      line_state.frame_begun = 1'b0;
      case (cmd)
         CMD_TICK: begin
            ppm_time = ppm_time + 1'b1;
            // The deadline counts as reached unless it lies less than half
            // the counter range ahead.
            lead = ppm_deadline - ppm_time;
            if (ppm_running && (lead == '0 || lead[TIME_BITS-1])) begin
               if (ppm_in_gap) begin
                  ppm_pulse = 1'b0;
                  ppm_deadline = ppm_time + TIME_BITS'(ppm_cfg.gap_length);
               end else begin
                  slots_used = (ppm_cfg.num_channels > MAX_CHANNELS) ?
                               SLOT_BITS'(MAX_CHANNELS) : ppm_cfg.num_channels;
                  if (ppm_slot == '0) begin
                     ppm_frame_start = ppm_time;
                     line_state.frame_begun = 1'b1;
                  end
                  ppm_pulse = 1'b1;
                  if (ppm_slot < slots_used) begin
                     ppm_deadline = ppm_time +
                                    TIME_BITS'(ppm_widths[ppm_slot[TBL_ADDR_BITS-1:0]]);
                     ppm_slot = ppm_slot + 1'b1;
                  end else begin
                     // Sync slot: stretch the pulse until one gap before the end of the frame.
                     ppm_deadline = ppm_frame_start + TIME_BITS'(ppm_cfg.frame_length) -
                                    TIME_BITS'(ppm_cfg.gap_length);
                     ppm_slot = '0;
                  end
               end
               ppm_in_gap = ~ppm_in_gap;
            end
         end
         CMD_WRITE: begin
            ppm_widths[index] = width;
         end
         CMD_RESTART: begin
            ppm_running = 1'b1;
            ppm_in_gap = 1'b0;
            ppm_time = '0;
            ppm_frame_start = '0;
            ppm_deadline = '0;
            ppm_slot = '0;
            ppm_pulse = 1'b0;
         end
         default: begin
            ppm_running = 1'b0;
         end
      endcase
      line_state.line_level = ppm_pulse ^ ppm_cfg.invert_output;
      line_state.slot = ppm_slot;
      line_state.running = ppm_running;
      return line_state;
   endfunction

   // Offer one request transaction, pacing the sender in bursts with gaps.
   task automatic send_req(cmd_type cmd, logic [INDEX_BITS-1:0] index,
                           logic [WIDTH_BITS-1:0] width, bit typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      if (csr_valid) csr_valid <= 1'b0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_channel_index <= index;
      req_channel_width <= width;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = ppm_advance(cmd, index, width);
      expected_line_states.push_back(typed ? want : predicted);
   endtask

   // Write one register once every expected transaction has come back.
   task automatic write_reg(csr_index_type sel, logic [CSR_DATA_BITS-1:0] value);
      req_valid <= 1'b0;
      while (expected_line_states.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (sel)
         CSR_NUM_CHANNELS:  ppm_cfg.num_channels = value[SLOT_BITS-1:0];
         CSR_INVERT_OUTPUT: ppm_cfg.invert_output = value[0];
         CSR_GAP_LENGTH:    ppm_cfg.gap_length = value;
         CSR_FRAME_LENGTH:  ppm_cfg.frame_length = value;
         default: ;
      endcase
   endtask

   // Main sequence: reset, directed table, then random phases.
   initial begin : stimulus
      int                      phase;
      int                      n_items;
      int                      k;
      int                      pick;
      logic [SLOT_BITS-1:0]    nch_sel;
      logic [15:0]             gap_sel;
      logic [15:0]             frame_sel;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_TICK;
      req_channel_index <= '0;
      req_channel_width <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_NUM_CHANNELS;
      csr_data <= '0;
      mismatch_count = 0;
      burst_left = 0;
      stall_hold_request = 1'b0;
      ppm_cfg = '{RESET_NUM_CHANNELS, 1'b0, RESET_GAP_LENGTH, RESET_FRAME_LENGTH};
      ppm_time = '0;
      ppm_deadline = '0;
      ppm_frame_start = '0;
      ppm_in_gap = 1'b0;
      ppm_slot = '0;
      ppm_running = 1'b0;
      ppm_pulse = 1'b0;
      foreach (ppm_widths[i]) ppm_widths[i] = DEFAULT_WIDTH;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_PLAN[r]) begin
         if (DIR_PLAN[r].to_csr) begin
            write_reg(DIR_PLAN[r].reg_sel, DIR_PLAN[r].reg_value);
         end else begin
            send_req(DIR_PLAN[r].cmd, DIR_PLAN[r].index, DIR_PLAN[r].width,
                     DIR_PLAN[r].typed, DIR_PLAN[r].want);
         end
      end

      // Each phase sets a configuration, loads short widths, restarts and
      // then runs mostly ticks with occasional writes, restarts and halts.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               nch_sel = 5'd3;
               gap_sel = 16'($urandom_range(0, 2));
               frame_sel = 16'($urandom_range(0, 30));
               n_items = 100;
            end
            1: begin
               nch_sel = 5'd16;
               gap_sel = 16'd1;
               frame_sel = 16'($urandom_range(40, 200));
               n_items = 100;
            end
            2: begin
               nch_sel = 5'd1;
               gap_sel = 16'hFFFF;
               frame_sel = 16'hFFFF;
               n_items = 30;
            end
            3: begin
               nch_sel = 5'd0;
               gap_sel = 16'($urandom_range(0, 3));
               frame_sel = 16'($urandom_range(0, 20));
               n_items = 100;
            end
            default: begin
               nch_sel = 5'($urandom_range(0, 31));
               gap_sel = 16'($urandom_range(0, 4));
               frame_sel = 16'($urandom_range(0, 120));
               n_items = 110;
            end
         endcase
         write_reg(CSR_NUM_CHANNELS, CSR_DATA_BITS'(nch_sel));
         write_reg(CSR_INVERT_OUTPUT, CSR_DATA_BITS'($urandom_range(0, 1)));
         write_reg(CSR_GAP_LENGTH, gap_sel);
         write_reg(CSR_FRAME_LENGTH, frame_sel);
         if (phase == 0 || phase == 3) stall_hold_request = 1'b1;
         for (k = 0; k < MAX_CHANNELS; k++) begin
            send_req(CMD_WRITE, INDEX_BITS'(k), WIDTH_BITS'($urandom_range(0, 6)), 1'b0, '0);
         end
         send_req(CMD_RESTART, INDEX_BITS'($urandom()), WIDTH_BITS'($urandom()), 1'b0, '0);
         for (k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
               send_req(CMD_TICK, INDEX_BITS'($urandom()), WIDTH_BITS'($urandom()),
                        1'b0, '0);
            end else if (pick < 93) begin
               send_req(CMD_WRITE, INDEX_BITS'($urandom()),
                        ($urandom_range(0, 15) == 0) ? WIDTH_BITS'($urandom()) :
                                                        WIDTH_BITS'($urandom_range(0, 8)),
                        1'b0, '0);
            end else if (pick < 97) begin
               send_req(CMD_RESTART, INDEX_BITS'($urandom()), WIDTH_BITS'($urandom()),
                        1'b0, '0);
            end else begin
               send_req(CMD_HALT, INDEX_BITS'($urandom()), WIDTH_BITS'($urandom()),
                        1'b0, '0);
            end
         end
      end

      // Drain, then wait for stray transactions before judging.
      req_valid <= 1'b0;
      while (expected_line_states.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS ppm_frame_generator");
      end else begin
         $display("FAIL ppm_frame_generator");
      end
      $finish;
   end

   // Receiver: segments of free flow, light, periodic and heavy stalling,
   // plus a long hold-off whenever the sequence asks for one.
   initial begin : receiver
      int seg_len;
      int mode;
      int i;
      rsp_stall <= 1'b0;
      forever begin
         if (stall_hold_request) begin
            stall_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         seg_len = $urandom_range(5, 60);
         mode = $urandom_range(0, 3);
         for (i = 0; i < seg_len; i++) begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 2) == 0);
               2:       rsp_stall <= (i % 4 == 3);
               default: rsp_stall <= ($urandom_range(0, 2) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Check every accepted response transaction against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type exp_state;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_line_states.size() == 0) begin
            $display("%0t: unexpected response, got level %0b slot %0d begun %0b running %0b",
                     $time, rsp_line_level, rsp_slot, rsp_frame_begun, rsp_running);
            mismatch_count++;
         end else begin
            exp_state = expected_line_states.pop_front();
            if (rsp_line_level !== exp_state.line_level) begin
               $display("%0t: line_level expected %0b got %0b",
                        $time, exp_state.line_level, rsp_line_level);
               mismatch_count++;
            end
            if (rsp_slot !== exp_state.slot) begin
               $display("%0t: slot expected %0d got %0d", $time, exp_state.slot, rsp_slot);
               mismatch_count++;
            end
            if (rsp_frame_begun !== exp_state.frame_begun) begin
               $display("%0t: frame_begun expected %0b got %0b",
                        $time, exp_state.frame_begun, rsp_frame_begun);
               mismatch_count++;
            end
            if (rsp_running !== exp_state.running) begin
               $display("%0t: running expected %0b got %0b",
                        $time, exp_state.running, rsp_running);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("FAIL ppm_frame_generator");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule
